// ===== rtl/shop_pkg.sv =====
// Shared types and constants for the staggered hop accumulator.
// No dependencies; used by every module of the block.
package shop_pkg;

    localparam int PACK_W = 64;
    localparam int HALF_W = 32;
    localparam int CPX_N  = 3;
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = 2;

    // One classified item as passed from front to back.
    typedef struct packed {
        logic [PACK_W-1:0] l00;
        logic [PACK_W-1:0] l01;
        logic [PACK_W-1:0] l02;
        logic [PACK_W-1:0] l10;
        logic [PACK_W-1:0] l11;
        logic [PACK_W-1:0] l12;
        logic [PACK_W-1:0] v0;
        logic [PACK_W-1:0] v1;
        logic [PACK_W-1:0] v2;
        logic              neg;
        logic              back;
        logic              last;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_THIRD,
        ST_ROW,
        ST_ACC,
        ST_EMIT
    } bk_state_t;

endpackage

// ===== rtl/shop_front.sv =====
// Front part: accepts input items and queues them for the back part.
// Depends on shop_pkg.
module shop_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  shop_pkg::cmd_t  in_cmd,
    output logic            cmd_valid,
    input  logic            cmd_take,
    output shop_pkg::cmd_t  cmd
);

    shop_pkg::cmd_t                    mem [shop_pkg::CMD_DEPTH];
    logic [shop_pkg::CMD_PTR_W-1:0]    wr_reg, rd_reg;
    logic [shop_pkg::CMD_PTR_W:0]      cnt_reg;
    logic                              do_push, do_pop;

    assign full      = (cnt_reg == 3'(shop_pkg::CMD_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;
    assign cmd       = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push) wr_reg <= wr_reg + 1'b1;
            if (do_pop)  rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + {2'b0, do_push} - {2'b0, do_pop};
        end
    end

endmodule

// ===== rtl/shop_back.sv =====
// Back part: rebuilds the third link row, forms U*v or U^H*v one row per step
// and accumulates; emits halved, saturated sums on the last item. Uses shop_pkg.
module shop_back #(
    parameter int PART_WIDTH = 32,
    parameter int FRAC_BITS  = 24,
    parameter int ACC_WIDTH  = 40
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_take,
    input  shop_pkg::cmd_t  cmd,
    output logic            empty,
    input  logic            pop,
    output logic [63:0]     out_c0,
    output logic [63:0]     out_c1,
    output logic [63:0]     out_c2
);

    localparam int PW = PART_WIDTH;
    localparam int PRW = 2 * PART_WIDTH;
    // Rounded products keep 2*PW-FRAC_BITS bits; sums of up to six need a few more.
    localparam int SW = (2 * PART_WIDTH - FRAC_BITS + 4 > PART_WIDTH + 2) ?
                        (2 * PART_WIDTH - FRAC_BITS + 4) : (PART_WIDTH + 2);
    localparam int AW = ACC_WIDTH;
    localparam int NW = ((SW > AW) ? SW : AW) + 1;

    typedef logic signed [PW-1:0]  part_t;
    typedef logic signed [PW:0]    opd_t;
    typedef logic signed [PRW-1:0] prod_t;
    typedef logic signed [SW-1:0]  sum_t;

    shop_pkg::bk_state_t state_reg, state_next;
    logic [1:0]  step_reg, step_next;

    part_t m_re [3][3];
    part_t m_im [3][3];
    part_t v_re [3];
    part_t v_im [3];
    part_t t_re_reg [3];
    part_t t_im_reg [3];
    logic signed [AW-1:0] acc_re_reg [3];
    logic signed [AW-1:0] acc_im_reg [3];
    prod_t pr_reg [12];
    prod_t xi_reg [4];
    logic  out_valid_reg;
    logic [63:0] o_reg [3];

    function automatic prod_t rnd(input prod_t p);
        prod_t t;
        t = p + (prod_t'(1) <<< (FRAC_BITS - 1));
        return t >>> FRAC_BITS;
    endfunction

    function automatic part_t sat_p(input sum_t x);
        sum_t hi, lo;
        hi = sum_t'((64'sd1 <<< (PW - 1)) - 1);
        lo = -hi - sum_t'(1);
        if (x > hi) return part_t'(hi);
        if (x < lo) return part_t'(lo);
        return part_t'(x);
    endfunction

    function automatic part_t sx(input logic [31:0] h);
        return part_t'(h[PW-1:0]);
    endfunction

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            m_re[0][j] = '0; m_im[0][j] = '0; m_re[1][j] = '0; m_im[1][j] = '0;
        end
        m_re[0][0] = sx(cmd.l00[63:32]); m_im[0][0] = sx(cmd.l00[31:0]);
        m_re[0][1] = sx(cmd.l01[63:32]); m_im[0][1] = sx(cmd.l01[31:0]);
        m_re[0][2] = sx(cmd.l02[63:32]); m_im[0][2] = sx(cmd.l02[31:0]);
        m_re[1][0] = sx(cmd.l10[63:32]); m_im[1][0] = sx(cmd.l10[31:0]);
        m_re[1][1] = sx(cmd.l11[63:32]); m_im[1][1] = sx(cmd.l11[31:0]);
        m_re[1][2] = sx(cmd.l12[63:32]); m_im[1][2] = sx(cmd.l12[31:0]);
        for (int j = 0; j < 3; j++)
        begin
            m_re[2][j] = t_re_reg[j];
            m_im[2][j] = t_im_reg[j];
        end
        v_re[0] = sx(cmd.v0[63:32]); v_im[0] = sx(cmd.v0[31:0]);
        v_re[1] = sx(cmd.v1[63:32]); v_im[1] = sx(cmd.v1[31:0]);
        v_re[2] = sx(cmd.v2[63:32]); v_im[2] = sx(cmd.v2[31:0]);
    end

    // Third row: one column per step, with the cross-product operands chosen by step.
    logic [1:0] ia, ib, ic, id;
    always_comb
    begin
        case (step_reg)
            2'd0:    begin ia = 2'd1; ib = 2'd2; ic = 2'd2; id = 2'd1; end
            2'd1:    begin ia = 2'd2; ib = 2'd0; ic = 2'd0; id = 2'd2; end
            default: begin ia = 2'd0; ib = 2'd1; ic = 2'd1; id = 2'd0; end
        endcase
    end

    // Multiplier operands: four complex products a*b per cycle.
    // One extra bit holds the conjugate of the most negative part.
    opd_t ar [4], ai [4], br [4], bi [4];
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            ar[k] = '0; ai[k] = '0; br[k] = '0; bi[k] = '0;
        end
        if (state_reg == shop_pkg::ST_THIRD)
        begin
            ar[0] = opd_t'(m_re[0][ia]); ai[0] = opd_t'(m_im[0][ia]);
            br[0] = opd_t'(m_re[1][ib]); bi[0] = opd_t'(m_im[1][ib]);
            ar[1] = opd_t'(m_re[0][ic]); ai[1] = opd_t'(m_im[0][ic]);
            br[1] = opd_t'(m_re[1][id]); bi[1] = opd_t'(m_im[1][id]);
        end
        else
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (cmd.back)
                begin
                    ar[j] = opd_t'(m_re[j][step_reg]);
                    ai[j] = -opd_t'(m_im[j][step_reg]);
                end
                else
                begin
                    ar[j] = opd_t'(m_re[step_reg][j]); ai[j] = opd_t'(m_im[step_reg][j]);
                end
                br[j] = opd_t'(v_re[j]); bi[j] = opd_t'(v_im[j]);
            end
        end
    end

    // Rounded products from the previous register stage.
    prod_t rp [12];
    always_comb
    begin
        for (int k = 0; k < 12; k++)
            rp[k] = rnd(pr_reg[k]);
    end

    sum_t x_re [4], x_im [4];
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            x_re[k] = sum_t'(rp[3*k]) - sum_t'(rp[3*k+1]);
            x_im[k] = sum_t'(rp[3*k+2]) + sum_t'(rnd(xi_reg[k]));
        end
    end

    sum_t t_re_s, t_im_s, sr, si;
    logic signed [NW-1:0] ar_new [3], ai_new [3];
    logic [1:0] pstep_reg;

    always_comb
    begin
        t_re_s = x_re[0] - x_re[1];
        t_im_s = -(x_im[0] - x_im[1]);
        if (cmd.neg)
        begin
            t_re_s = -t_re_s;
            t_im_s = -t_im_s;
        end
        sr = x_re[0] + x_re[1] + x_re[2];
        si = x_im[0] + x_im[1] + x_im[2];
    end

    function automatic logic signed [AW-1:0] sat_a(input logic signed [NW-1:0] x);
        logic signed [NW-1:0] hi, lo;
        hi = NW'((64'sd1 <<< (AW - 1)) - 1);
        lo = -hi - NW'(1);
        if (x > hi) return AW'(hi);
        if (x < lo) return AW'(lo);
        return AW'(x);
    endfunction

    function automatic logic [31:0] half_out(input logic signed [AW-1:0] a);
        logic signed [AW:0] h;
        sum_t hs;
        logic signed [AW:0] hi, lo;
        h  = ((AW+1)'(a) + (AW+1)'(1)) >>> 1;
        hi = (AW+1)'((64'sd1 <<< (PW - 1)) - 1);
        lo = -hi - (AW+1)'(1);
        if (h > hi) h = hi;
        if (h < lo) h = lo;
        hs = sum_t'(h);
        return 32'(signed'(sat_p(hs)));
    endfunction

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ar_new[i] = NW'(acc_re_reg[i]);
            ai_new[i] = NW'(acc_im_reg[i]);
        end
        if (cmd.back)
        begin
            ar_new[pstep_reg] = NW'(acc_re_reg[pstep_reg]) - NW'(sr);
            ai_new[pstep_reg] = NW'(acc_im_reg[pstep_reg]) - NW'(si);
        end
        else
        begin
            ar_new[pstep_reg] = NW'(acc_re_reg[pstep_reg]) + NW'(sr);
            ai_new[pstep_reg] = NW'(acc_im_reg[pstep_reg]) + NW'(si);
        end
    end

    logic phase_reg, phase_next;
    logic busy_mul;
    assign busy_mul = (state_reg == shop_pkg::ST_THIRD) || (state_reg == shop_pkg::ST_ROW);

    // Next state: each multiply step runs a product phase, then a combine phase.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        phase_next = phase_reg;
        case (state_reg)
            shop_pkg::ST_IDLE:
            begin
                if (cmd_valid && !out_valid_reg)
                begin
                    state_next = shop_pkg::ST_THIRD;
                    step_next  = 2'd0;
                    phase_next = 1'b0;
                end
            end
            shop_pkg::ST_THIRD, shop_pkg::ST_ROW:
            begin
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    if (step_reg == 2'd2)
                    begin
                        step_next  = 2'd0;
                        state_next = (state_reg == shop_pkg::ST_THIRD) ?
                                     shop_pkg::ST_ROW : shop_pkg::ST_ACC;
                    end
                    else
                    begin
                        step_next = step_reg + 2'd1;
                    end
                end
            end
            shop_pkg::ST_ACC:
            begin
                state_next = cmd.last ? shop_pkg::ST_EMIT : shop_pkg::ST_IDLE;
            end
            shop_pkg::ST_EMIT:
            begin
                state_next = shop_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = shop_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        case (state_reg)
            shop_pkg::ST_ACC: cmd_take = !cmd.last;
            shop_pkg::ST_EMIT: cmd_take = 1'b1;
            default: cmd_take = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            pr_reg[3*k]   <= prod_t'(ar[k]) * prod_t'(br[k]);
            pr_reg[3*k+1] <= prod_t'(ai[k]) * prod_t'(bi[k]);
            pr_reg[3*k+2] <= prod_t'(ar[k]) * prod_t'(bi[k]);
            xi_reg[k]     <= prod_t'(ai[k]) * prod_t'(br[k]);
        end
        pstep_reg <= step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= shop_pkg::ST_IDLE;
            step_reg      <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                acc_re_reg[i] <= '0;
                acc_im_reg[i] <= '0;
                t_re_reg[i]   <= '0;
                t_im_reg[i]   <= '0;
                o_reg[i]      <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            phase_reg <= phase_next;
            if (busy_mul && phase_reg)
            begin
                if (state_reg == shop_pkg::ST_THIRD)
                begin
                    t_re_reg[pstep_reg] <= sat_p(t_re_s);
                    t_im_reg[pstep_reg] <= sat_p(t_im_s);
                end
                else
                begin
                    acc_re_reg[pstep_reg] <= sat_a(ar_new[pstep_reg]);
                    acc_im_reg[pstep_reg] <= sat_a(ai_new[pstep_reg]);
                end
            end
            if (state_reg == shop_pkg::ST_EMIT)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    o_reg[i] <= {half_out(acc_re_reg[i]), half_out(acc_im_reg[i])};
                    acc_re_reg[i] <= '0;
                    acc_im_reg[i] <= '0;
                end
                out_valid_reg <= 1'b1;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign empty  = !out_valid_reg;
    assign out_c0 = o_reg[0];
    assign out_c1 = o_reg[1];
    assign out_c2 = o_reg[2];

endmodule

// ===== rtl/staggered_su3_hop_accumulate.sv =====
// Top level of the staggered SU(3) hop accumulator: input queue plus sequenced back end.
// Depends on shop_pkg, shop_front and shop_back.
//
//  channel   direction  handshake     payload
//  input     in         push / full   link_r*_c*, nbr_c*, eta_negative, mode, last
//  result    out        empty / pop   out_c0..out_c2
//
// In the back end an item passes a dispatch step, three third-row columns and three
// result rows, each through the shared four-product multiplier bank in a product
// and a combine phase, then accumulate; the last item of a site adds an emit step.
// Reset clears the queue, the accumulators and the result register at once.
// A waiting result stalls the back end; the four-deep queue keeps taking items.
module staggered_su3_hop_accumulate #(
    parameter int PART_WIDTH = 32,
    parameter int FRAC_BITS  = 24,
    parameter int ACC_WIDTH  = 40
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [63:0] link_r0_c0,
    input  logic [63:0] link_r0_c1,
    input  logic [63:0] link_r0_c2,
    input  logic [63:0] link_r1_c0,
    input  logic [63:0] link_r1_c1,
    input  logic [63:0] link_r1_c2,
    input  logic [63:0] nbr_c0,
    input  logic [63:0] nbr_c1,
    input  logic [63:0] nbr_c2,
    input  logic        eta_negative,
    input  logic        mode,
    input  logic        last,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] out_c0,
    output logic [63:0] out_c1,
    output logic [63:0] out_c2
);

    shop_pkg::cmd_t in_cmd, cmd;
    logic           cmd_valid, cmd_take;

    assign in_cmd = '{l00: link_r0_c0, l01: link_r0_c1, l02: link_r0_c2,
                      l10: link_r1_c0, l11: link_r1_c1, l12: link_r1_c2,
                      v0: nbr_c0, v1: nbr_c1, v2: nbr_c2,
                      neg: eta_negative, back: mode, last: last};

    shop_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_cmd    (in_cmd),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd)
    );

    shop_back #(
        .PART_WIDTH (PART_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .ACC_WIDTH  (ACC_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd),
        .empty     (empty),
        .pop       (pop),
        .out_c0    (out_c0),
        .out_c1    (out_c1),
        .out_c2    (out_c2)
    );

endmodule

// ===== verif/staggered_su3_hop_accumulate_test.sv =====
// Testbench for staggered_su3_hop_accumulate: drives link/vector items through the
// push/full queue and checks every emitted site sum against a built-in predictor.
// Depends on the RTL top level only; no package items are needed at the ports.
module staggered_su3_hop_accumulate_test;

    localparam int PW = 32;
    localparam int FB = 24;
    localparam int AW = 40;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        longint re;
        longint im;
    } cpx_t;

    typedef struct {
        logic [63:0] l [6];
        logic [63:0] v [3];
        logic        neg;
        logic        back;
        logic        last;
    } hop_item_t;

    typedef struct {
        logic [63:0] c [3];
    } site_sum_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [63:0] link_r0_c0, link_r0_c1, link_r0_c2;
    logic [63:0] link_r1_c0, link_r1_c1, link_r1_c2;
    logic [63:0] nbr_c0, nbr_c1, nbr_c2;
    logic        eta_negative;
    logic        mode;
    logic        last;
    logic        empty;
    logic        pop;
    logic [63:0] out_c0, out_c1, out_c2;

    longint      acc_re [3];
    longint      acc_im [3];
    site_sum_t   sum_queue [$];
    int          mismatch_count;
    int          send_idle_pct;
    int          pop_idle_pct;
    bit          hold_pop;
    int          hold_cycles;
    int          quiet_cycles;

    staggered_su3_hop_accumulate i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .link_r0_c0   (link_r0_c0),
        .link_r0_c1   (link_r0_c1),
        .link_r0_c2   (link_r0_c2),
        .link_r1_c0   (link_r1_c0),
        .link_r1_c1   (link_r1_c1),
        .link_r1_c2   (link_r1_c2),
        .nbr_c0       (nbr_c0),
        .nbr_c1       (nbr_c1),
        .nbr_c2       (nbr_c2),
        .eta_negative (eta_negative),
        .mode         (mode),
        .last         (last),
        .empty        (empty),
        .pop          (pop),
        .out_c0       (out_c0),
        .out_c1       (out_c1),
        .out_c2       (out_c2)
    );

    always #2 clk = ~clk;

    // ---------------- predictor ----------------

    function automatic longint sat(longint x, int w);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (x > hi)
            return hi;
        if (x < lo)
            return lo;
        return x;
    endfunction

    // Arithmetic shift of a signed longint is a floor.
    function automatic longint rnd_prod(longint a, longint b);
        return (a * b + (64'sd1 <<< (FB - 1))) >>> FB;
    endfunction

    function automatic cpx_t unpack_cpx(logic [63:0] p);
        cpx_t c;
        c.re = longint'(signed'(p[63:32]));
        c.im = longint'(signed'(p[31:0]));
        return c;
    endfunction

    function automatic cpx_t cpx_mul(cpx_t a, cpx_t b);
        cpx_t r;
        r.re = rnd_prod(a.re, b.re) - rnd_prod(a.im, b.im);
        r.im = rnd_prod(a.re, b.im) + rnd_prod(a.im, b.re);
        return r;
    endfunction

    function automatic cpx_t third_row_entry(cpx_t p, cpx_t q, cpx_t r, cpx_t s, logic neg);
        cpx_t x;
        cpx_t y;
        cpx_t t;
        x = cpx_mul(p, q);
        y = cpx_mul(r, s);
        t.re = x.re - y.re;
        t.im = -(x.im - y.im);
        if (neg)
        begin
            t.re = -t.re;
            t.im = -t.im;
        end
        t.re = sat(t.re, PW);
        t.im = sat(t.im, PW);
        return t;
    endfunction

    task automatic accumulate_hop(input hop_item_t it);
        cpx_t      u [3][3];
        cpx_t      v [3];
        cpx_t      p;
        cpx_t      cu;
        longint    sr;
        longint    si;
        longint    hr;
        longint    hi;
        site_sum_t s;
        for (int j = 0; j < 3; j++)
        begin
            u[0][j] = unpack_cpx(it.l[j]);
            u[1][j] = unpack_cpx(it.l[3 + j]);
            v[j] = unpack_cpx(it.v[j]);
        end
        u[2][0] = third_row_entry(u[0][1], u[1][2], u[0][2], u[1][1], it.neg);
        u[2][1] = third_row_entry(u[0][2], u[1][0], u[0][0], u[1][2], it.neg);
        u[2][2] = third_row_entry(u[0][0], u[1][1], u[0][1], u[1][0], it.neg);
        for (int i = 0; i < 3; i++)
        begin
            sr = 0;
            si = 0;
            for (int j = 0; j < 3; j++)
            begin
                if (it.back)
                begin
                    cu = u[j][i];
                    cu.im = -cu.im;
                    p = cpx_mul(cu, v[j]);
                end
                else
                    p = cpx_mul(u[i][j], v[j]);
                sr += p.re;
                si += p.im;
            end
            if (it.back)
            begin
                acc_re[i] = sat(acc_re[i] - sr, AW);
                acc_im[i] = sat(acc_im[i] - si, AW);
            end
            else
            begin
                acc_re[i] = sat(acc_re[i] + sr, AW);
                acc_im[i] = sat(acc_im[i] + si, AW);
            end
        end
        if (it.last)
        begin
            for (int i = 0; i < 3; i++)
            begin
                hr = sat((acc_re[i] + 1) >>> 1, PW);
                hi = sat((acc_im[i] + 1) >>> 1, PW);
                s.c[i] = {hr[31:0], hi[31:0]};
                acc_re[i] = 0;
                acc_im[i] = 0;
            end
            sum_queue.push_back(s);
        end
    endtask

    // ---------------- checking ----------------

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        site_sum_t w;
        logic [63:0] got [3];
        if (rst_n && pop && !empty)
        begin
            got[0] = out_c0;
            got[1] = out_c1;
            got[2] = out_c2;
            if (sum_queue.size() == 0)
                report_mismatch("unexpected site sum", got[0], 64'd0);
            else
            begin
                w = sum_queue.pop_front();
                for (int i = 0; i < 3; i++)
                    if (got[i] !== w.c[i])
                        report_mismatch($sformatf("out_c%0d", i), got[i], w.c[i]);
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (hold_cycles > 0)
        begin
            pop <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            pop <= ($urandom_range(99) >= pop_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------- stimulus ----------------

    function automatic logic [63:0] rand_cpx(int kind);
        logic [31:0] re;
        logic [31:0] im;
        case (kind)
            0: begin re = $urandom; im = $urandom; end
            // near-unit magnitudes, typical of an SU(3) element
            1: begin
                re = 32'($signed($urandom_range(2 << FB)) - (1 << FB));
                im = 32'($signed($urandom_range(2 << FB)) - (1 << FB));
            end
            default: begin
                re = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
                im = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            end
        endcase
        return {re, im};
    endfunction

    function automatic hop_item_t rand_hop(logic is_last);
        hop_item_t it;
        int kind;
        kind = $urandom_range(9) < 7 ? 1 : ($urandom_range(3) == 0 ? 2 : 0);
        for (int k = 0; k < 6; k++)
            it.l[k] = rand_cpx(kind);
        for (int k = 0; k < 3; k++)
            it.v[k] = rand_cpx(kind);
        it.neg = 1'($urandom_range(1));
        it.back = 1'($urandom_range(1));
        it.last = is_last;
        return it;
    endfunction

    // Leave push high after the accepting edge; the next item or an idle drops it.
    task automatic send_hop(input hop_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        link_r0_c0 <= it.l[0];
        link_r0_c1 <= it.l[1];
        link_r0_c2 <= it.l[2];
        link_r1_c0 <= it.l[3];
        link_r1_c1 <= it.l[4];
        link_r1_c2 <= it.l[5];
        nbr_c0 <= it.v[0];
        nbr_c1 <= it.v[1];
        nbr_c2 <= it.v[2];
        eta_negative <= it.neg;
        mode <= it.back;
        last <= it.last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        accumulate_hop(it);
        @(negedge clk);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (sum_queue.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_directed();
        hop_item_t it;
        logic [63:0] pats [6];
        pats = '{64'd0, 64'h7fffffff_7fffffff, 64'h80000000_80000000,
                 64'h01000000_00000000, 64'h00000000_ff000000, 64'hffffffff_00000001};
        // single-item sites over extreme patterns, both modes and signs
        for (int k = 0; k < 16; k++)
        begin
            for (int j = 0; j < 6; j++)
                it.l[j] = pats[(k + j) % 6];
            for (int j = 0; j < 3; j++)
                it.v[j] = pats[(k + 2 * j + 1) % 6];
            it.neg = k[0];
            it.back = k[1];
            it.last = 1'b1;
            send_hop(it);
        end
        // drive accumulators into saturation over two four-item sites, one per direction
        for (int k = 0; k < 8; k++)
        begin
            for (int j = 0; j < 6; j++)
                it.l[j] = 64'h7fffffff_7fffffff;
            for (int j = 0; j < 3; j++)
                it.v[j] = 64'h7fffffff_7fffffff;
            it.neg = 1'b0;
            it.back = (k >= 4);
            it.last = (k == 3 || k == 7);
            send_hop(it);
        end
        drain_results();
    endtask

    task automatic test_random_sites(input int n_items);
        int left;
        int run;
        left = n_items;
        while (left > 0)
        begin
            // mostly eight-link sites, sometimes short or odd lengths
            run = $urandom_range(3) == 0 ? $urandom_range(1, 12) : 8;
            for (int k = 0; k < run && left > 0; k++)
            begin
                send_hop(rand_hop(k == run - 1 || left == 1));
                left--;
            end
        end
        drain_results();
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        for (int k = 0; k < 40; k++)
            send_hop(rand_hop(1'($urandom_range(1))));
        send_hop(rand_hop(1'b1));
        drain_results();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        {link_r0_c0, link_r0_c1, link_r0_c2} = '0;
        {link_r1_c0, link_r1_c1, link_r1_c2} = '0;
        {nbr_c0, nbr_c1, nbr_c2} = '0;
        eta_negative = 1'b0;
        mode = 1'b0;
        last = 1'b0;
        mismatch_count = 0;
        hold_cycles = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        pop_idle_pct = 0;
        for (int i = 0; i < 3; i++)
        begin
            acc_re[i] = 0;
            acc_im[i] = 0;
        end
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        send_idle_pct = 32;
        pop_idle_pct = 86;
        test_random_sites(500);
        send_idle_pct = 86;
        pop_idle_pct = 32;
        test_random_sites(500);
        send_idle_pct = 0;
        pop_idle_pct = 0;
        test_random_sites(460);
        test_backpressure();

        repeat (40) @(negedge clk);
        if (mismatch_count == 0 && sum_queue.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
